// File: design/kja_pkg.sv
`default_nettype none
package kja_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int WORD_W = 64;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [WORD_W-1:0] word_t;
    typedef logic [2:0] op_t;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    localparam op_t OP_LAST = 3'd0;
    localparam op_t OP_SUM  = 3'd1;
    localparam op_t OP_MIN  = 3'd2;
    localparam op_t OP_MAX  = 3'd3;
    localparam op_t OP_OR   = 3'd4;
    localparam op_t OP_AND  = 3'd5;

    localparam word_t LLONG_MAX_BITS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam word_t LLONG_MIN_BITS = 64'h8000_0000_0000_0000;
    localparam word_t ALL_ONES       = 64'hFFFF_FFFF_FFFF_FFFF;

    localparam int USR_DEFINED = 0;
    localparam int USR_ALL_DEF = 1;
    localparam int USR_FULL    = 2;

    typedef struct packed {
        logic  en;
        cmd_t  cmd;
        word_t key;
        logic  present;
    } cam_req_t;

    typedef struct packed {
        logic hit;
        idx_t hit_idx;
        logic free_ok;
        idx_t free_idx;
    } cam_rsp_t;

    typedef struct packed {
        logic  en;
        idx_t  idx;
        word_t data;
    } ram_wr_t;

    function automatic word_t op_identity(input op_t op);
        word_t r;
        unique case (op)
            OP_MIN:  r = LLONG_MAX_BITS;
            OP_MAX:  r = LLONG_MIN_BITS;
            OP_AND:  r = ALL_ONES;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic word_t op_fold(input op_t op, input word_t acc, input word_t v);
        word_t r;
        unique case (op)
            OP_SUM:  r = acc + v;
            OP_MIN:  r = ($signed(v) < $signed(acc)) ? v : acc;
            OP_MAX:  r = ($signed(acc) < $signed(v)) ? v : acc;
            OP_OR:   r = acc | v;
            OP_AND:  r = acc & v;
            default: r = v;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// File: design/keyed_join_aggregate_table.sv
// Pipeline: a beat passes the a, b and output registers before its result is valid.
// Throughput: one beat per cycle while m_tready does not stall the output; set by
// the combinational key compare across all table entries and the one-read one-write
// aggregate RAM with write bypass. Reset: aresetn synchronous, active low; empties
// all entries at once, sets join_op to 0 and all_defined to 1. No clearing pass.
`default_nettype none
module keyed_join_aggregate_table
    import kja_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_data,   // join_op
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,    // row_key, row_value
    input  wire logic [2:0]   s_tuser,    // command[1:0], row_present
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [63:0]       m_tdata,    // result_value
    output logic [2:0]        m_tuser     // result_defined, all_defined, table_full
);

    op_t      join_op_reg;
    logic     all_def_reg;

    logic     a_valid_reg;
    cmd_t     a_cmd_reg;
    word_t    a_key_reg;
    word_t    a_value_reg;
    logic     a_present_reg;

    logic     b_valid_reg;
    cmd_t     b_cmd_reg;
    word_t    b_value_reg;
    logic     b_hit_reg;
    logic     b_alloc_reg;
    logic     b_full_reg;
    idx_t     b_idx_reg;

    logic     out_valid_reg;
    word_t    out_value_reg;
    logic     out_defined_reg;
    logic     out_all_def_reg;
    logic     out_full_reg;

    logic     en_out;
    logic     en_b;
    logic     en_a;
    cam_req_t cam_req;
    cam_rsp_t cam_rsp;
    ram_wr_t  ram_wr;
    logic     rd_en;
    idx_t     rd_idx;
    word_t    rd_data;

    word_t    ident;
    word_t    acc;
    word_t    res_value;
    logic     res_defined;
    logic     res_full;
    logic     all_def_next;
    logic     a_alloc;
    logic     a_full;

    assign en_out    = !out_valid_reg || m_tready;
    assign en_b      = !b_valid_reg || en_out;
    assign en_a      = !a_valid_reg || en_b;
    assign s_tready  = en_a;
    assign cfg_ready = 1'b1;

    assign cam_req.en      = en_b && a_valid_reg;
    assign cam_req.cmd     = a_cmd_reg;
    assign cam_req.key     = a_key_reg;
    assign cam_req.present = a_present_reg;

    kja_cam u_cam (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (cam_req),
        .rsp     (cam_rsp)
    );

    assign rd_en  = en_b && a_valid_reg;
    assign rd_idx = cam_rsp.hit ? cam_rsp.hit_idx : cam_rsp.free_idx;

    kja_agg_ram u_ram (
        .aclk    (aclk),
        .wr      (ram_wr),
        .rd_en   (rd_en),
        .rd_idx  (rd_idx),
        .rd_data (rd_data)
    );

    assign a_alloc = (a_cmd_reg == CMD_LOAD) && a_present_reg && !cam_rsp.hit
                     && cam_rsp.free_ok;
    assign a_full  = (a_cmd_reg == CMD_LOAD) && a_present_reg && !cam_rsp.hit
                     && !cam_rsp.free_ok;

    always_comb begin
        ident        = op_identity(join_op_reg);
        acc          = b_alloc_reg ? ident : rd_data;
        ram_wr.en    = b_valid_reg && en_out && (b_cmd_reg == CMD_LOAD)
                       && (b_hit_reg || b_alloc_reg);
        ram_wr.idx   = b_idx_reg;
        ram_wr.data  = op_fold(join_op_reg, acc, b_value_reg);
        res_value    = '0;
        res_defined  = 1'b0;
        res_full     = 1'b0;
        all_def_next = all_def_reg;
        unique case (b_cmd_reg)
            CMD_LOAD: begin
                res_full = b_full_reg;
            end
            CMD_QUERY: begin
                res_value    = b_hit_reg ? rd_data : ident;
                res_defined  = b_hit_reg;
                all_def_next = all_def_reg && b_hit_reg;
            end
            CMD_CLEAR: begin
                all_def_next = 1'b1;
            end
            CMD_NONE: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            join_op_reg   <= OP_LAST;
            all_def_reg   <= 1'b1;
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                join_op_reg <= cfg_data;
            end
            if (en_a) begin
                a_valid_reg <= s_tvalid;
            end
            if (en_b) begin
                b_valid_reg <= a_valid_reg;
            end
            if (en_out) begin
                out_valid_reg <= b_valid_reg;
                if (b_valid_reg) begin
                    all_def_reg <= all_def_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en_a && s_tvalid) begin
            a_cmd_reg     <= cmd_t'(s_tuser[1:0]);
            a_present_reg <= s_tuser[2];
            a_key_reg     <= s_tdata[63:0];
            a_value_reg   <= s_tdata[127:64];
        end
        if (en_b && a_valid_reg) begin
            b_cmd_reg   <= a_cmd_reg;
            b_value_reg <= a_value_reg;
            b_hit_reg   <= cam_rsp.hit;
            b_alloc_reg <= a_alloc;
            b_full_reg  <= a_full;
            b_idx_reg   <= rd_idx;
        end
        if (en_out && b_valid_reg) begin
            out_value_reg   <= res_value;
            out_defined_reg <= res_defined;
            out_all_def_reg <= all_def_next;
            out_full_reg    <= res_full;
        end
    end

    assign m_tvalid              = out_valid_reg;
    assign m_tdata               = out_value_reg;
    assign m_tuser[USR_DEFINED]  = out_defined_reg;
    assign m_tuser[USR_ALL_DEF]  = out_all_def_reg;
    assign m_tuser[USR_FULL]     = out_full_reg;

`ifndef ASSERT_OFF
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_wr.en |-> !b_full_reg)
        else $error("aggregate write issued for a dropped load");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (b_valid_reg && en_out && (b_cmd_reg == CMD_CLEAR)) |=> all_def_reg)
        else $error("all_defined not set after clear");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[USR_DEFINED] && m_tuser[USR_FULL]))
        else $error("result both defined and full");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (b_valid_reg && b_hit_reg) |-> !b_alloc_reg)
        else $error("matched key also allocated an entry");
`endif

endmodule
`default_nettype wire

// File: design/kja_cam.sv
`default_nettype none
module kja_cam
    import kja_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire cam_req_t req,
    output cam_rsp_t      rsp
);

    word_t                  key_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [TABLE_DEPTH-1:0] match;
    logic                   any_match;
    logic                   alloc;

    always_comb begin
        rsp = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            match[i] = valid_reg[i] && (key_mem[i] == req.key);
        end
        any_match = |match;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (match[i]) begin
                rsp.hit_idx = IDX_W'(i);
            end
            if (!valid_reg[i]) begin
                rsp.free_idx = IDX_W'(i);
                rsp.free_ok  = 1'b1;
            end
        end
        rsp.hit = req.present && any_match;
        alloc = req.en && (req.cmd == CMD_LOAD) && req.present && !any_match && rsp.free_ok;
    end

    always_ff @(posedge aclk) begin
        if (alloc) begin
            key_mem[rsp.free_idx] <= req.key;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (req.en && (req.cmd == CMD_CLEAR)) begin
            valid_reg <= '0;
        end else if (alloc) begin
            valid_reg[rsp.free_idx] <= 1'b1;
        end
    end

endmodule
`default_nettype wire

// File: design/kja_agg_ram.sv
`default_nettype none
module kja_agg_ram
    import kja_pkg::*;
(
    input  wire logic    aclk,
    input  wire ram_wr_t wr,
    input  wire logic    rd_en,
    input  wire idx_t    rd_idx,
    output word_t        rd_data
);

    word_t mem [TABLE_DEPTH];
    word_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.idx] <= wr.data;
        end
    end

    // bypass a write landing in the same cycle as the read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= (wr.en && (wr.idx == rd_idx)) ? wr.data : mem[rd_idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import kja_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASES = 20;
    localparam int PHASE_ROWS = 100;

    typedef struct packed {
        word_t value;
        logic  defined;
        logic  all_def;
        logic  full;
    } agg_result_t;

    typedef struct packed {
        logic        set_cfg;
        op_t         op;
        cmd_t        cmd;
        word_t       key;
        word_t       val;
        logic        present;
        logic        fixed;
        agg_result_t want;
    } stim_row_t;

    typedef struct packed {
        logic        fixed;
        agg_result_t want;
    } row_note_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_data = 3'd0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [127:0] s_tdata = '0;     // row_key, row_value
    logic [2:0] s_tuser = '0;       // command[1:0], row_present
    logic m_tvalid;
    logic m_tready = 1'b1;
    logic [63:0] m_tdata;           // result_value
    logic [2:0] m_tuser;            // result_defined, all_defined, table_full

    keyed_join_aggregate_table uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // predictor state
    word_t tbl_key [TABLE_DEPTH];
    word_t tbl_agg [TABLE_DEPTH];
    logic  tbl_used [TABLE_DEPTH];
    logic  every_query_defined = 1'b1;
    op_t   cur_op = OP_LAST;

    agg_result_t pending_results[$];
    row_note_t   row_notes[$];

    int errors = 0;
    int reported = 0;
    int cycles = 0;
    int tx_idle_pct = 17;
    int rx_idle_pct = 17;
    int hold_asks = 0;
    int hold_served = 0;
    int hold_left = 0;
    int n_rows = 0;
    int n_hits = 0;
    int n_misses = 0;
    int n_dropped = 0;
    int n_clears = 0;
    int n_cfg = 0;

    function automatic word_t neutral_of(op_t op);
        case (op)
            OP_MIN: return LLONG_MAX_BITS;
            OP_MAX: return LLONG_MIN_BITS;
            OP_AND: return ALL_ONES;
            default: return '0;
        endcase
    endfunction

    function automatic word_t merge_value(op_t op, word_t acc, word_t v);
        case (op)
            OP_SUM: return acc + v;
            OP_MIN: return ($signed(v) < $signed(acc)) ? v : acc;
            OP_MAX: return ($signed(v) > $signed(acc)) ? v : acc;
            OP_OR:  return acc | v;
            OP_AND: return acc & v;
            default: return v;
        endcase
    endfunction

    function automatic agg_result_t fold_and_lookup(cmd_t cmd, word_t key, word_t val,
                                                    logic present);
        agg_result_t r;
        int hit;
        int slot;
        r = '0;
        hit = -1;
        slot = -1;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (tbl_used[i] && tbl_key[i] == key && hit < 0)
                hit = i;
            if (!tbl_used[i] && slot < 0)
                slot = i;
        end
        case (cmd)
            CMD_LOAD: begin
                if (present) begin
                    if (hit >= 0) begin
                        tbl_agg[hit] = merge_value(cur_op, tbl_agg[hit], val);
                    end else if (slot >= 0) begin
                        tbl_used[slot] = 1'b1;
                        tbl_key[slot] = key;
                        tbl_agg[slot] = merge_value(cur_op, neutral_of(cur_op), val);
                    end else begin
                        r.full = 1'b1;
                    end
                end
            end
            CMD_QUERY: begin
                if (present && hit >= 0) begin
                    r.value = tbl_agg[hit];
                    r.defined = 1'b1;
                end else begin
                    r.value = neutral_of(cur_op);
                    every_query_defined = 1'b0;
                end
            end
            CMD_CLEAR: begin
                for (int i = 0; i < TABLE_DEPTH; i++)
                    tbl_used[i] = 1'b0;
                every_query_defined = 1'b1;
            end
            default: ;
        endcase
        r.all_def = every_query_defined;
        return r;
    endfunction

    function automatic void note_miss(string what, word_t want, word_t got);
        errors++;
        if (reported < 10) begin
            reported++;
            $display("mismatch on %s: expected %h, got %h", what, want, got);
        end
    endfunction

    initial begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            tbl_used[i] = 1'b0;
            tbl_key[i] = '0;
            tbl_agg[i] = '0;
        end
    end

    // scoreboard: results first, then accepted rows and register writes
    always @(posedge aclk) begin
        agg_result_t want;
        agg_result_t pred;
        row_note_t note;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    note_miss("unexpected beat", '0, m_tdata);
                end else begin
                    want = pending_results.pop_front();
                    if (m_tdata !== want.value)
                        note_miss("result_value", want.value, m_tdata);
                    if (m_tuser[USR_DEFINED] !== want.defined)
                        note_miss("result_defined", want.defined, m_tuser[USR_DEFINED]);
                    if (m_tuser[USR_ALL_DEF] !== want.all_def)
                        note_miss("all_defined", want.all_def, m_tuser[USR_ALL_DEF]);
                    if (m_tuser[USR_FULL] !== want.full)
                        note_miss("table_full", want.full, m_tuser[USR_FULL]);
                end
            end
            if (s_tvalid && s_tready) begin
                note = row_notes.pop_front();
                pred = fold_and_lookup(cmd_t'(s_tuser[1:0]), s_tdata[63:0],
                                       s_tdata[127:64], s_tuser[2]);
                pending_results.push_back(note.fixed ? note.want : pred);
                n_rows++;
                if (cmd_t'(s_tuser[1:0]) == CMD_QUERY) begin
                    if (pred.defined)
                        n_hits++;
                    else
                        n_misses++;
                end
                if (cmd_t'(s_tuser[1:0]) == CMD_CLEAR)
                    n_clears++;
                if (pred.full)
                    n_dropped++;
            end
            if (cfg_valid && cfg_ready) begin
                cur_op = op_t'(cfg_data);
                n_cfg++;
            end
        end
    end

    // receiver: random stalls, plus long hold-offs on request
    always @(negedge aclk) begin
        if (hold_left == 0 && hold_asks != hold_served) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic push_row(cmd_t cmd, word_t key, word_t val, logic present,
                            logic fixed, agg_result_t want);
        row_note_t note;
        note.fixed = fixed;
        note.want = want;
        while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        row_notes.push_back(note);
        s_tvalid <= 1'b1;
        s_tdata <= {val, key};
        s_tuser <= {present, cmd};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0 || row_notes.size() != 0)
            @(negedge aclk);
    endtask

    task automatic set_join_op(op_t op);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data <= op;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic stim_row_t mk_cfg(op_t op);
        stim_row_t r;
        r = '0;
        r.set_cfg = 1'b1;
        r.op = op;
        return r;
    endfunction

    function automatic stim_row_t mk_row(cmd_t cmd, word_t key, word_t val, logic present,
                                         logic fixed, word_t value, logic defined,
                                         logic all_def, logic full);
        stim_row_t r;
        r = '0;
        r.cmd = cmd;
        r.key = key;
        r.val = val;
        r.present = present;
        r.fixed = fixed;
        r.want.value = value;
        r.want.defined = defined;
        r.want.all_def = all_def;
        r.want.full = full;
        return r;
    endfunction

    function automatic word_t rand_word();
        case ($urandom_range(0, 9))
            0: return LLONG_MIN_BITS;
            1: return LLONG_MAX_BITS;
            2: return ALL_ONES;
            3: return '0;
            4: return word_t'($signed($urandom_range(0, 200)) - 100);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial begin
        stim_row_t script[$];
        stim_row_t row;
        word_t key_pool[$];
        agg_result_t none;
        op_t op;
        int pool_n;
        int seq;
        int pick;
        logic fill;
        none = '0;

        script.push_back(mk_row(CMD_QUERY, 64'd5, '0, 1, 1, '0, 0, 0, 0));
        script.push_back(mk_row(CMD_CLEAR, '0, '0, 1, 1, '0, 0, 1, 0));
        script.push_back(mk_row(CMD_LOAD, LLONG_MIN_BITS, LLONG_MAX_BITS, 1, 1, '0, 0, 1, 0));
        script.push_back(mk_row(CMD_LOAD, LLONG_MIN_BITS, 64'h5555_5555_5555_5555, 1,
                                1, '0, 0, 1, 0));
        script.push_back(mk_row(CMD_LOAD, 64'd7, 64'd1, 0, 1, '0, 0, 1, 0));
        script.push_back(mk_row(CMD_QUERY, LLONG_MIN_BITS, '0, 1, 1,
                                64'h5555_5555_5555_5555, 1, 1, 0));
        script.push_back(mk_row(CMD_QUERY, 64'd7, '0, 1, 1, '0, 0, 0, 0));
        script.push_back(mk_row(CMD_NONE, LLONG_MIN_BITS, ALL_ONES, 1, 1, '0, 0, 0, 0));
        script.push_back(mk_row(CMD_CLEAR, ALL_ONES, ALL_ONES, 0, 1, '0, 0, 1, 0));
        script.push_back(mk_cfg(OP_SUM));
        script.push_back(mk_row(CMD_LOAD, ALL_ONES, LLONG_MAX_BITS, 1, 0, '0, 0, 0, 0));
        script.push_back(mk_row(CMD_LOAD, ALL_ONES, 64'd1, 1, 0, '0, 0, 0, 0));
        script.push_back(mk_row(CMD_QUERY, ALL_ONES, '0, 1, 1, LLONG_MIN_BITS, 1, 1, 0));
        script.push_back(mk_row(CMD_QUERY, ALL_ONES, '0, 0, 1, '0, 0, 0, 0));
        script.push_back(mk_cfg(OP_MIN));
        script.push_back(mk_row(CMD_LOAD, ALL_ONES, 64'd5, 1, 0, '0, 0, 0, 0));
        script.push_back(mk_row(CMD_QUERY, 64'd99, '0, 1, 1, LLONG_MAX_BITS, 0, 0, 0));
        script.push_back(mk_row(CMD_CLEAR, '0, '0, 0, 1, '0, 0, 1, 0));
        script.push_back(mk_cfg(OP_MAX));
        script.push_back(mk_row(CMD_LOAD, '0, LLONG_MIN_BITS, 1, 0, '0, 0, 0, 0));
        script.push_back(mk_row(CMD_QUERY, '0, '0, 1, 0, '0, 0, 0, 0));
        script.push_back(mk_row(CMD_QUERY, 64'd1, '0, 1, 1, LLONG_MIN_BITS, 0, 0, 0));
        script.push_back(mk_cfg(OP_AND));
        script.push_back(mk_row(CMD_LOAD, '0, ALL_ONES, 1, 0, '0, 0, 0, 0));
        script.push_back(mk_row(CMD_QUERY, 64'd3, '0, 0, 1, ALL_ONES, 0, 0, 0));
        script.push_back(mk_cfg(OP_OR));
        script.push_back(mk_row(CMD_LOAD, '0, 64'h0123_4567_89AB_CDEF, 1, 0, '0, 0, 0, 0));
        script.push_back(mk_row(CMD_QUERY, '0, '0, 1, 0, '0, 0, 0, 0));
        script.push_back(mk_cfg(op_t'(3'd7)));
        script.push_back(mk_row(CMD_QUERY, 64'd42, '0, 1, 1, '0, 0, 0, 0));
        script.push_back(mk_row(CMD_LOAD, '0, 64'd9, 1, 0, '0, 0, 0, 0));
        script.push_back(mk_row(CMD_QUERY, '0, '0, 1, 0, '0, 0, 0, 0));

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (script[i]) begin
            row = script[i];
            if (row.set_cfg)
                set_join_op(row.op);
            else
                push_row(row.cmd, row.key, row.val, row.present, row.fixed, row.want);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            op = (ph < 8) ? op_t'(ph) : op_t'($urandom_range(0, 7));
            fill = (ph % 5 == 3);
            case ($urandom_range(0, 4))
                0: pool_n = 2;
                1: pool_n = 6;
                2: pool_n = 20;
                3: pool_n = 50;
                default: pool_n = 64;
            endcase
            if (fill)
                pool_n = $urandom_range(72, 100);
            key_pool.delete();
            for (int k = 0; k < pool_n; k++)
                key_pool.push_back(rand_word());
            seq = 0;
            set_join_op(op);
            tx_idle_pct = (ph == 2) ? 0 : 17;
            rx_idle_pct = (ph == 2) ? 0 : 17;
            if (ph == 4 || ph == 13)
                hold_asks++;
            if (fill || $urandom_range(0, 2) == 0)
                push_row(CMD_CLEAR, rand_word(), rand_word(), 1'($urandom_range(0, 1)), 0,
                         none);
            for (int n = 0; n < PHASE_ROWS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    push_row(CMD_LOAD,
                             fill ? key_pool[seq % pool_n]
                                  : key_pool[$urandom_range(0, pool_n - 1)],
                             rand_word(), 1'b1, 0, none);
                    seq++;
                end else if (pick < 60) begin
                    push_row(CMD_LOAD, key_pool[$urandom_range(0, pool_n - 1)],
                             rand_word(), 1'b0, 0, none);
                end else if (pick < 82) begin
                    push_row(CMD_QUERY, key_pool[$urandom_range(0, pool_n - 1)],
                             rand_word(), 1'b1, 0, none);
                end else if (pick < 87) begin
                    push_row(CMD_QUERY, rand_word(), rand_word(), 1'b1, 0, none);
                end else if (pick < 91) begin
                    push_row(CMD_QUERY, key_pool[$urandom_range(0, pool_n - 1)],
                             rand_word(), 1'b0, 0, none);
                end else if (pick < 95 && !fill) begin
                    push_row(CMD_CLEAR, rand_word(), rand_word(),
                             1'($urandom_range(0, 1)), 0, none);
                end else begin
                    push_row(CMD_NONE, rand_word(), rand_word(),
                             1'($urandom_range(0, 1)), 0, none);
                end
            end
        end

        drain_results();
        repeat (8) @(posedge aclk);
        errors += pending_results.size();
        $display("covered %0d row beats over %0d join_op writes, incl. all eight codes",
                 n_rows, n_cfg);
        $display("queries matched %0d, missed %0d; loads dropped on full table %0d; clears %0d",
                 n_hits, n_misses, n_dropped, n_clears);
        if (errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

// File: filelist.f
design/kja_pkg.sv
design/kja_cam.sv
design/kja_agg_ram.sv
design/keyed_join_aggregate_table.sv
test/tb_top.sv
